// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the rectangle fill core.
// Needs nothing else; define NO_ASSERTIONS to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define ASSERT_AT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("property violated");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle property violated");

`else

`define ASSERT_AT(lbl, clk, rst_n, prop)

`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/tpfb_pkg.sv -----
// Shared types, constants and helper functions of the rectangle fill core.
// No dependencies.
package tpfb_pkg;

  localparam int PANEL_SHORT_SIDE = 128;
  localparam int PANEL_LONG_SIDE  = 256;
  localparam int PLANE_BYTES      = 4096;

  localparam int COORD_W = 9;
  localparam int EXT_W   = COORD_W + 1;
  localparam int IDX_W   = 12;
  localparam int ADDR_W  = $clog2(PLANE_BYTES);

  localparam int PIX_MAX  = PANEL_SHORT_SIDE * PANEL_LONG_SIDE;
  localparam int BITS_MAX = PLANE_BYTES * 8;
  localparam int LIN_MAX0 = (PIX_MAX > BITS_MAX) ? PIX_MAX : BITS_MAX;
  localparam int LIN_MAX  = (LIN_MAX0 > 1024) ? LIN_MAX0 : 1024;
  localparam int LIN_W    = $clog2(LIN_MAX) + 1;
  localparam int IDX_CMP_W = (IDX_W > ADDR_W) ? IDX_W + 1 : ADDR_W + 1;

  localparam logic [1:0] COLOR_BLACK = 2'd1;
  localparam logic [1:0] COLOR_RED   = 2'd2;

  typedef enum logic [1:0] {
    MODE_RECT   = 2'd0,
    MODE_SCREEN = 2'd1,
    MODE_READ   = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ORIENT_PORTRAIT      = 2'd0,
    ORIENT_LANDSCAPE     = 2'd1,
    ORIENT_PORTRAIT_REV  = 2'd2,
    ORIENT_LANDSCAPE_REV = 2'd3
  } orient_e;

  typedef struct packed {
    mode_e              mode;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] rect_width;
    logic [COORD_W-1:0] rect_height;
    logic [1:0]         color;
    logic               plane;
    logic [IDX_W-1:0]   byte_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       rejected;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic sweep_en;
    logic sweep_white;
    logic pix_rd;
    logic pix_wr;
    logic byte_rd;
  } dp_cmd_t;

  typedef struct packed {
    mode_e mode;
    logic  reject;
    logic  empty;
    logic  last_x;
    logic  last_y;
    logic  sweep_last;
  } dp_status_t;

  // Plane bit is cleared only where the pixel has that plane's color.
  function automatic logic black_fill(logic [1:0] color);
    return color != COLOR_BLACK;
  endfunction

  function automatic logic red_fill(logic [1:0] color);
    return color != COLOR_RED;
  endfunction

endpackage

// ----- rtl/core/tpfb_datapath.sv -----
// Datapath of the rectangle fill core: item registers, pixel address math,
// the two plane memories and the sweep counter. Depends on tpfb_pkg.
module tpfb_datapath import tpfb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i,
  input  in_item_t   item_i,
  input  dp_cmd_t    cmd_i,
  output dp_status_t status_o,
  output out_item_t  result_o
);

  orient_e             orientation_q;
  in_item_t            item_q;
  logic [COORD_W-1:0]  x_q, y_q;
  logic [EXT_W-1:0]    x_end_q, y_end_q;
  logic [ADDR_W-1:0]   sweep_cnt_q;
  logic [ADDR_W-1:0]   off_q;
  logic                in_range_q;
  logic [7:0]          mask_q;
  logic [7:0]          rd_black_q, rd_red_q;

  logic [7:0] black_mem [PLANE_BYTES];
  logic [7:0] red_mem   [PLANE_BYTES];

  logic [EXT_W-1:0]  scr_w, scr_h, in_w, in_h, in_xe, in_ye;
  logic [LIN_W-1:0]  x_l, y_l, mul_a, prod, lin;
  logic [2:0]        bit_sel;
  logic              idx_ok;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic              rd_en, wr_en;
  logic [7:0]        wr_black, wr_red, fill_black, fill_red;

  assign scr_w = orientation_q[0] ? EXT_W'(PANEL_LONG_SIDE) : EXT_W'(PANEL_SHORT_SIDE);
  assign scr_h = orientation_q[0] ? EXT_W'(PANEL_SHORT_SIDE) : EXT_W'(PANEL_LONG_SIDE);

  // Clip the rectangle at the right and bottom edges.
  always_comb begin
    in_w  = EXT_W'(item_i.x_start) + EXT_W'(item_i.rect_width);
    in_h  = EXT_W'(item_i.y_start) + EXT_W'(item_i.rect_height);
    in_xe = (in_w > scr_w) ? scr_w : in_w;
    in_ye = (in_h > scr_h) ? scr_h : in_h;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      orientation_q <= ORIENT_PORTRAIT;
    end else if (cfg_we_i) begin
      orientation_q <= orient_e'(cfg_wdata_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sweep_cnt_q <= '0;
    end else if (cmd_i.sweep_en) begin
      sweep_cnt_q <= status_o.sweep_last ? '0 : sweep_cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q  <= item_i;
      x_q     <= item_i.x_start;
      y_q     <= item_i.y_start;
      x_end_q <= in_xe;
      y_end_q <= in_ye;
    end else if (cmd_i.pix_wr) begin
      // Walk y inside, x outside.
      if (status_o.last_y) begin
        y_q <= item_q.y_start;
        x_q <= x_q + 1'b1;
      end else begin
        y_q <= y_q + 1'b1;
      end
    end
  end

  // Linear bit index of pixel (x_q, y_q); the multiplier constant is the
  // short side in every orientation.
  always_comb begin
    x_l = LIN_W'(x_q);
    y_l = LIN_W'(y_q);
    unique case (orientation_q)
      ORIENT_PORTRAIT:     mul_a = y_l;
      ORIENT_LANDSCAPE:    mul_a = x_l;
      ORIENT_PORTRAIT_REV: mul_a = y_l;
      default:             mul_a = LIN_W'(scr_w) - LIN_W'(1) - x_l;
    endcase
    prod = mul_a * LIN_W'(PANEL_SHORT_SIDE);
    unique case (orientation_q)
      ORIENT_PORTRAIT: begin
        lin     = prod + x_l;
        bit_sel = ~x_q[2:0];
      end
      ORIENT_LANDSCAPE: begin
        lin     = prod + LIN_W'(scr_h) - LIN_W'(1) - y_l;
        bit_sel = y_q[2:0];
      end
      ORIENT_PORTRAIT_REV: begin
        lin     = LIN_W'(PIX_MAX - 1) - prod - x_l;
        bit_sel = x_q[2:0];
      end
      default: begin
        lin     = prod + y_l;
        bit_sel = ~y_q[2:0];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pix_rd) begin
      off_q      <= lin[ADDR_W+2:3];
      in_range_q <= lin < LIN_W'(BITS_MAX);
      mask_q     <= 8'b1 << bit_sel;
    end
  end

  assign idx_ok = IDX_CMP_W'(item_q.byte_index) < IDX_CMP_W'(PLANE_BYTES);

  assign fill_black = (cmd_i.sweep_white || black_fill(item_q.color)) ? 8'hFF : 8'h00;
  assign fill_red   = (cmd_i.sweep_white || red_fill(item_q.color))   ? 8'hFF : 8'h00;

  always_comb begin
    rd_en   = cmd_i.pix_rd || cmd_i.byte_rd;
    rd_addr = cmd_i.byte_rd ? ADDR_W'(item_q.byte_index) : lin[ADDR_W+2:3];
    wr_en   = cmd_i.sweep_en || (cmd_i.pix_wr && in_range_q);
    if (cmd_i.sweep_en) begin
      wr_addr  = sweep_cnt_q;
      wr_black = fill_black;
      wr_red   = fill_red;
    end else begin
      wr_addr  = off_q;
      wr_black = black_fill(item_q.color) ? (rd_black_q | mask_q) : (rd_black_q & ~mask_q);
      wr_red   = red_fill(item_q.color) ? (rd_red_q | mask_q) : (rd_red_q & ~mask_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      black_mem[wr_addr] <= wr_black;
      red_mem[wr_addr]   <= wr_red;
    end
    if (rd_en) begin
      rd_black_q <= black_mem[rd_addr];
      rd_red_q   <= red_mem[rd_addr];
    end
  end

  always_comb begin
    status_o.mode       = item_q.mode;
    status_o.reject     = (EXT_W'(item_q.x_start) >= scr_w) ||
                          (EXT_W'(item_q.y_start) >= scr_h);
    status_o.empty      = (item_q.rect_width == '0) || (item_q.rect_height == '0);
    status_o.last_x     = (EXT_W'(x_q) + 1'b1) == x_end_q;
    status_o.last_y     = (EXT_W'(y_q) + 1'b1) == y_end_q;
    status_o.sweep_last = sweep_cnt_q == ADDR_W'(PLANE_BYTES - 1);
  end

  always_comb begin
    result_o.rejected  = (item_q.mode == MODE_RECT) && status_o.reject;
    result_o.read_data = '0;
    if (item_q.mode == MODE_READ && idx_ok) begin
      result_o.read_data = item_q.plane ? rd_red_q : rd_black_q;
    end
  end

endmodule

// ----- rtl/core/tpfb_ctrl.sv -----
// Controller of the rectangle fill core: sequences the clearing pass, pixel
// read-modify-write, screen sweep and byte read. Depends on tpfb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module tpfb_ctrl import tpfb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy,
  output logic       done_o
);

  typedef enum logic [7:0] {
    ST_INIT   = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_CHECK  = 8'b0000_0100,
    ST_PIX_RD = 8'b0000_1000,
    ST_PIX_WR = 8'b0001_0000,
    ST_FILL   = 8'b0010_0000,
    ST_READ   = 8'b0100_0000,
    ST_RESULT = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign busy   = !(state_q == ST_IDLE || state_q == ST_RESULT);
  assign accept = start && !busy;
  assign done_o = state_q == ST_RESULT;

  always_comb begin
    cmd_o             = '0;
    cmd_o.load        = accept;
    cmd_o.sweep_en    = (state_q == ST_INIT) || (state_q == ST_FILL);
    cmd_o.sweep_white = state_q == ST_INIT;
    cmd_o.pix_rd      = state_q == ST_PIX_RD;
    cmd_o.pix_wr      = state_q == ST_PIX_WR;
    cmd_o.byte_rd     = state_q == ST_READ;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (status_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE, ST_RESULT: begin
        state_d = accept ? ST_CHECK : ST_IDLE;
      end
      ST_CHECK: begin
        unique case (status_i.mode)
          MODE_RECT:   state_d = (status_i.reject || status_i.empty) ? ST_RESULT : ST_PIX_RD;
          MODE_SCREEN: state_d = ST_FILL;
          MODE_READ:   state_d = ST_READ;
          default:     state_d = ST_RESULT;
        endcase
      end
      ST_PIX_RD: state_d = ST_PIX_WR;
      ST_PIX_WR: begin
        state_d = (status_i.last_x && status_i.last_y) ? ST_RESULT : ST_PIX_RD;
      end
      ST_FILL: begin
        if (status_i.sweep_last) state_d = ST_RESULT;
      end
      ST_READ: state_d = ST_RESULT;
      default: state_d = ST_INIT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_NEXT(a_done_single, clk_i, rst_ni, done_o, !done_o)
  `ASSERT_NEXT(a_accept_check, clk_i, rst_ni, start && !busy, state_q == ST_CHECK)
  `ASSERT_AT(a_wr_after_rd, clk_i, rst_ni, (state_q == ST_PIX_WR) |-> ($past(state_q) == ST_PIX_RD))

endmodule

// ----- rtl/core/two_plane_framebuffer_rect_fill_core.sv -----
// Top level of the two-plane rectangle fill core: controller plus datapath.
// Depends on tpfb_pkg, tpfb_ctrl and tpfb_datapath.
//
//   channel   direction  handshake              payload
//   item      in         start && !busy         item_i (in_item_t)
//   result    out        done_o, one cycle      result_o (out_item_t)
//   config    in         cfg_we_i               cfg_wdata_i (orientation)
//
// After reset a clearing pass writes white into both planes, with busy high.
// A rectangle does one plane read and one plane write per pixel. The result
// cycle overlaps acceptance of the next item. The receiver cannot stall:
// each result shows for one cycle.
module two_plane_framebuffer_rect_fill_core import tpfb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  in_item_t   item_i,
  output logic       done_o,
  output out_item_t  result_o,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_wdata_i
);

  dp_cmd_t    cmd;
  dp_status_t status;

  tpfb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  tpfb_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (result_o)
  );

endmodule
